@@ src/gnss_fix_to_local_pose_macros.svh @@
// ---------------------------------------------------------------------------
// GNSS fix to local pose: assertion macros
// Shared forms for the concurrent checks, sampled on clock, off in reset.
// ---------------------------------------------------------------------------
`ifndef GNSS_FIX_TO_LOCAL_POSE_MACROS_SVH
`define GNSS_FIX_TO_LOCAL_POSE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GFTLP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GFTLP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/gftlp_pkg.sv @@
// ---------------------------------------------------------------------------
// GNSS fix to local pose: shared package
// Widths, fixed-point constants, sequencer states and the CORDIC arctangent
// table.
// ---------------------------------------------------------------------------
package gftlp_pkg;

   localparam int unsigned XyW   = 34;
   localparam int unsigned ZW    = 33;
   localparam int unsigned MulW  = 35;
   localparam int unsigned ProdW = 2 * MulW;
   localparam int unsigned CordicSteps = 28;
   localparam int unsigned StepW = $clog2(CordicSteps);

   localparam logic signed [MulW-1:0] MmPerUnitQ24  = 35'sd186554130;
   localparam logic signed [MulW-1:0] MeanlatToBam  = 35'sd2562047788;
   localparam logic signed [MulW-1:0] HalfangToBam  = 35'sd3909374677;
   localparam logic signed [XyW-1:0]  CordicGainQ30 = 34'sd652032874;

   localparam logic [1:0] FixNone = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BAM,
      ST_ROT_GO,
      ST_ROT_WAIT,
      ST_MUL,
      ST_OUT
   } gftlp_state_type;

   function automatic logic signed [ZW-1:0] atan_bam(input logic [StepW-1:0] idx);
      logic signed [ZW-1:0] v;
      case (idx)
         5'd0:  v = 33'sh020000000;
         5'd1:  v = 33'sh012E4051E;
         5'd2:  v = 33'sh009FB385B;
         5'd3:  v = 33'sh0051111D4;
         5'd4:  v = 33'sh0028B0D43;
         5'd5:  v = 33'sh00145D7E1;
         5'd6:  v = 33'sh000A2F61E;
         5'd7:  v = 33'sh000517C55;
         5'd8:  v = 33'sh00028BE53;
         5'd9:  v = 33'sh000145F2F;
         5'd10: v = 33'sh0000A2F98;
         5'd11: v = 33'sh0000517CC;
         5'd12: v = 33'sh000028BE6;
         5'd13: v = 33'sh0000145F3;
         5'd14: v = 33'sh00000A2FA;
         5'd15: v = 33'sh00000517D;
         5'd16: v = 33'sh0000028BE;
         5'd17: v = 33'sh00000145F;
         5'd18: v = 33'sh000000A30;
         5'd19: v = 33'sh000000518;
         5'd20: v = 33'sh00000028C;
         5'd21: v = 33'sh000000146;
         5'd22: v = 33'sh0000000A3;
         5'd23: v = 33'sh000000051;
         5'd24: v = 33'sh000000029;
         5'd25: v = 33'sh000000014;
         5'd26: v = 33'sh00000000A;
         5'd27: v = 33'sh000000005;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [ProdW-1:0] v);
      logic signed [31:0] r;
      if (v > 70'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -70'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

@@ src/gftlp_cordic.sv @@
// ---------------------------------------------------------------------------
// GNSS fix to local pose: iterative CORDIC
// Cosine and sine in Q30 of a 32-bit binary angle, one rotation step a cycle.
// ---------------------------------------------------------------------------
module gftlp_cordic import gftlp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [31:0]           angle,
   output logic                  done,
   output logic signed [XyW-1:0] cos_val,
   output logic signed [XyW-1:0] sin_val
);

   logic                  run_ff, run_in;
   logic                  done_ff, done_in;
   logic [StepW-1:0]      i_ff, i_in;
   logic [1:0]            q_ff, q_in;
   logic signed [XyW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]  z_ff, z_in;
   logic [31:0]           qsum, rem;
   logic signed [XyW-1:0] xs, ys;
   logic signed [ZW-1:0]  at;

   always_comb begin
      qsum = angle + 32'h20000000;
      rem  = angle - {qsum[31:30], 30'd0};
      xs   = x_ff >>> i_ff;
      ys   = y_ff >>> i_ff;
      at   = atan_bam(i_ff);
      run_in  = run_ff;
      done_in = 1'b0;
      i_in = i_ff;
      q_in = q_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (start) begin
         run_in = 1'b1;
         i_in = '0;
         q_in = qsum[31:30];
         x_in = CordicGainQ30;
         y_in = '0;
         z_in = $signed({rem[31], rem});
      end else if (run_ff) begin
         if (!z_ff[ZW-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         i_in = i_ff + 1'b1;
         if (i_ff == StepW'(CordicSteps - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      i_ff <= i_in;
      q_ff <= q_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   always_comb begin
      case (q_ff)
         2'd0: begin
            cos_val = x_ff;
            sin_val = y_ff;
         end
         2'd1: begin
            cos_val = -y_ff;
            sin_val = x_ff;
         end
         2'd2: begin
            cos_val = -x_ff;
            sin_val = -y_ff;
         end
         default: begin
            cos_val = y_ff;
            sin_val = -x_ff;
         end
      endcase
   end

   assign done = done_ff;

endmodule

@@ src/gnss_fix_to_local_pose.sv @@
// ---------------------------------------------------------------------------
// GNSS fix to local pose
// Maps a GNSS fix to a fix code, latches the first usable fix as reference,
// and gives a flat-earth ENU offset and an attitude quaternion.
//
//   channel | dir | handshake          | word
//   req_    | in  | req_valid/stall    | one GNSS fix
//   rsp_    | out | rsp_valid/stall    | one pose result
//
// A fix that yields a pose makes four passes of the shared CORDIC (one per
// angle) and twenty-four products on the shared multiplier, four of them to
// scale the angles. Other fixes go straight to the output state.
// req_stall is high from acceptance until the result enters the output
// register; a result waits there while rsp_stall is high.
// Reset is synchronous and clears the reference.
// ---------------------------------------------------------------------------
module gnss_fix_to_local_pose import gftlp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_module_ok,
   input  logic [1:0]         req_solution_class,
   input  logic signed [30:0] req_latitude,
   input  logic signed [31:0] req_longitude,
   input  logic signed [25:0] req_altitude,
   input  logic [15:0]        req_heading_angle,
   input  logic signed [14:0] req_pitch_angle,
   input  logic signed [15:0] req_roll_angle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_accepted,
   output logic [1:0]         rsp_fix_code,
   output logic               rsp_pose_valid,
   output logic signed [31:0] rsp_east_mm,
   output logic signed [31:0] rsp_north_mm,
   output logic signed [31:0] rsp_up_mm,
   output logic signed [15:0] rsp_quat_w,
   output logic signed [15:0] rsp_quat_x,
   output logic signed [15:0] rsp_quat_y,
   output logic signed [15:0] rsp_quat_z
);

   localparam logic [1:0] AngMean  = 2'd0;
   localparam logic [1:0] AngYaw   = 2'd1;
   localparam logic [1:0] AngPitch = 2'd2;
   localparam logic [1:0] AngRoll  = 2'd3;

   localparam logic [4:0] StepNorth  = 5'd0;
   localparam logic [4:0] StepLon    = 5'd1;
   localparam logic [4:0] StepEastHi = 5'd2;
   localparam logic [4:0] StepEastLo = 5'd3;
   localparam logic [4:0] StepQuat   = 5'd4;
   localparam logic [4:0] StepLast   = 5'd19;

   gftlp_state_type state_ff, state_in;

   logic               ok_ff, pose_ff;
   logic [1:0]         code_ff;
   logic signed [30:0] lat_ff;
   logic signed [31:0] lon_ff;
   logic signed [25:0] alt_ff;
   logic [15:0]        yaw_ff;
   logic signed [14:0] pitch_ff;
   logic signed [15:0] roll_ff;
   logic               ref_held_ff;
   logic signed [31:0] ref_lat_ff, ref_lon_ff, ref_alt_ff;

   logic [1:0]              ang_ff;
   logic                    neg_ff;
   logic signed [ProdW-1:0] prod_ff;
   logic [4:0]              step_ff;
   logic                    phase_ff;
   logic signed [XyW-1:0]   cm_ff, cy_ff, sy_ff, cp_ff, sp_ff, cr_ff, sr_ff;
   logic signed [44:0]      p8_ff;
   logic signed [XyW-1:0]   t_ff;
   logic signed [ProdW-1:0] acc_ff;
   logic signed [31:0]      north_ff, east_ff;
   logic signed [15:0]      qw_ff, qx_ff, qy_ff, qz_ff;

   logic               rsp_valid_ff, rsp_accepted_ff, rsp_pose_valid_ff;
   logic [1:0]         rsp_fix_code_ff;
   logic signed [31:0] rsp_east_ff, rsp_north_ff, rsp_up_ff;
   logic signed [15:0] rsp_qw_ff, rsp_qx_ff, rsp_qy_ff, rsp_qz_ff;

   logic                    accept, held_next, out_free, load_out;
   logic signed [32:0]      sum33, dlat, dlon, pitch33, roll33;
   logic [32:0]             mag;
   logic                    neg;
   logic [31:0]             bam_mag, bam;
   logic                    cordic_start, cordic_done;
   logic signed [XyW-1:0]   cordic_cos, cordic_sin;
   logic signed [XyW-1:0]   c16w;
   logic signed [19:0]      c16;
   logic [4:0]              qi;
   logic [2:0]              k;
   logic signed [XyW-1:0]   ta, tb, tc;
   logic signed [MulW-1:0]  opa, opb;
   logic signed [ProdW-1:0] mul, total, up_diff;

   function automatic logic signed [15:0] to_q14(input logic signed [ProdW-1:0] v);
      logic signed [ProdW-1:0] r;
      logic signed [15:0]      q;
      r = (v + (70'sd1 <<< 45)) >>> 46;
      if (r > 70'sd16384) begin
         q = 16'sd16384;
      end else if (r < -70'sd16384) begin
         q = -16'sd16384;
      end else begin
         q = r[15:0];
      end
      return q;
   endfunction

   gftlp_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .angle   (bam),
      .done    (cordic_done),
      .cos_val (cordic_cos),
      .sin_val (cordic_sin)
   );

   assign accept    = req_valid && !req_stall;
   assign held_next = ref_held_ff || (req_solution_class != 2'd0);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_out  = (state_ff == ST_OUT) && out_free;

   always_comb begin
      sum33   = 33'(lat_ff) + 33'(ref_lat_ff);
      dlat    = 33'(lat_ff) - 33'(ref_lat_ff);
      dlon    = 33'(lon_ff) - 33'(ref_lon_ff);
      pitch33 = 33'(pitch_ff);
      roll33  = 33'(roll_ff);
      case (ang_ff)
         AngMean: begin
            neg = sum33[32];
            mag = neg ? 33'(-sum33) : 33'(sum33);
         end
         AngYaw: begin
            neg = 1'b0;
            mag = {17'd0, yaw_ff};
         end
         AngPitch: begin
            neg = pitch33[32];
            mag = neg ? 33'(-pitch33) : 33'(pitch33);
         end
         default: begin
            neg = roll33[32];
            mag = neg ? 33'(-roll33) : 33'(roll33);
         end
      endcase
      bam_mag = (ang_ff == AngMean) ? prod_ff[63:32] : prod_ff[47:16];
      bam     = neg_ff ? (32'd0 - bam_mag) : bam_mag;

      c16w = (cm_ff + 34'sd8192) >>> 14;
      c16  = c16w[19:0];

      qi = step_ff - StepQuat;
      k  = qi[3:1];
      case (k)
         3'd0: begin ta = cr_ff; tb = cp_ff; tc = cy_ff; end
         3'd1: begin ta = sr_ff; tb = sp_ff; tc = sy_ff; end
         3'd2: begin ta = sr_ff; tb = cp_ff; tc = cy_ff; end
         3'd3: begin ta = cr_ff; tb = sp_ff; tc = sy_ff; end
         3'd4: begin ta = cr_ff; tb = sp_ff; tc = cy_ff; end
         3'd5: begin ta = sr_ff; tb = cp_ff; tc = sy_ff; end
         3'd6: begin ta = cr_ff; tb = cp_ff; tc = sy_ff; end
         default: begin ta = sr_ff; tb = sp_ff; tc = cy_ff; end
      endcase

      opa = '0;
      opb = '0;
      if (state_ff == ST_BAM) begin
         opa = $signed({2'b00, mag});
         opb = (ang_ff == AngMean) ? MeanlatToBam : HalfangToBam;
      end else if (state_ff == ST_MUL) begin
         case (step_ff)
            StepNorth: begin
               opa = 35'(dlat);
               opb = MmPerUnitQ24;
            end
            StepLon: begin
               opa = 35'(dlon);
               opb = MmPerUnitQ24;
            end
            StepEastHi: begin
               opa = 35'($signed(p8_ff[44:17]));
               opb = 35'(c16);
            end
            StepEastLo: begin
               opa = $signed({18'd0, p8_ff[16:0]});
               opb = 35'(c16);
            end
            default: begin
               opa = qi[0] ? 35'(t_ff) : 35'(ta);
               opb = qi[0] ? 35'(tc) : 35'(tb);
            end
         endcase
      end
      mul = opa * opb;

      if ((k == 3'd3) || (k == 3'd7)) begin
         total = acc_ff - prod_ff;
      end else begin
         total = acc_ff + prod_ff;
      end
      up_diff = 70'(alt_ff) - 70'(ref_alt_ff);
   end

   always_comb begin
      state_in     = state_ff;
      cordic_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_module_ok && held_next) ? ST_BAM : ST_OUT;
            end
         end
         ST_BAM: begin
            state_in = ST_ROT_GO;
         end
         ST_ROT_GO: begin
            cordic_start = 1'b1;
            state_in     = ST_ROT_WAIT;
         end
         ST_ROT_WAIT: begin
            if (cordic_done) begin
               state_in = (ang_ff == AngRoll) ? ST_MUL : ST_BAM;
            end
         end
         ST_MUL: begin
            if (phase_ff && (step_ff == StepLast)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_held_ff  <= 1'b0;
         ref_lat_ff   <= '0;
         ref_lon_ff   <= '0;
         ref_alt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept && req_module_ok && !ref_held_ff && (req_solution_class != 2'd0)) begin
            ref_held_ff <= 1'b1;
            ref_lat_ff  <= 32'(req_latitude);
            ref_lon_ff  <= req_longitude;
            ref_alt_ff  <= 32'(req_altitude);
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul;
      if (accept) begin
         ok_ff    <= req_module_ok;
         pose_ff  <= req_module_ok && held_next;
         code_ff  <= FixNone - req_solution_class;
         lat_ff   <= req_latitude;
         lon_ff   <= req_longitude;
         alt_ff   <= req_altitude;
         yaw_ff   <= req_heading_angle;
         pitch_ff <= req_pitch_angle;
         roll_ff  <= req_roll_angle;
         ang_ff   <= AngMean;
         step_ff  <= StepNorth;
         phase_ff <= 1'b0;
      end
      if (state_ff == ST_BAM) begin
         neg_ff <= neg;
      end
      if ((state_ff == ST_ROT_WAIT) && cordic_done) begin
         case (ang_ff)
            AngMean: begin
               cm_ff <= cordic_cos;
            end
            AngYaw: begin
               cy_ff <= cordic_cos;
               sy_ff <= cordic_sin;
            end
            AngPitch: begin
               cp_ff <= cordic_cos;
               sp_ff <= cordic_sin;
            end
            default: begin
               cr_ff <= cordic_cos;
               sr_ff <= cordic_sin;
            end
         endcase
         ang_ff <= ang_ff + 2'd1;
      end
      if (state_ff == ST_MUL) begin
         phase_ff <= !phase_ff;
         if (phase_ff) begin
            step_ff <= step_ff + 5'd1;
            case (step_ff)
               StepNorth: begin
                  north_ff <= sat32((prod_ff + 70'sd8388608) >>> 24);
               end
               StepLon: begin
                  p8_ff <= prod_ff[60:16];
               end
               StepEastHi: begin
                  acc_ff <= prod_ff <<< 17;
               end
               StepEastLo: begin
                  east_ff <= sat32((acc_ff + prod_ff + 70'sd8388608) >>> 24);
               end
               default: begin
                  if (!qi[0]) begin
                     t_ff <= prod_ff[63:30];
                  end else if (!k[0]) begin
                     acc_ff <= prod_ff;
                  end else begin
                     case (k[2:1])
                        2'd0: qw_ff <= to_q14(total);
                        2'd1: qx_ff <= to_q14(total);
                        2'd2: qy_ff <= to_q14(total);
                        default: qz_ff <= to_q14(total);
                     endcase
                  end
               end
            endcase
         end
      end
      if (load_out) begin
         rsp_accepted_ff   <= ok_ff;
         rsp_fix_code_ff   <= ok_ff ? code_ff : FixNone;
         rsp_pose_valid_ff <= pose_ff;
         rsp_east_ff       <= pose_ff ? east_ff : '0;
         rsp_north_ff      <= pose_ff ? north_ff : '0;
         rsp_up_ff         <= pose_ff ? sat32(up_diff) : '0;
         rsp_qw_ff         <= pose_ff ? qw_ff : '0;
         rsp_qx_ff         <= pose_ff ? qx_ff : '0;
         rsp_qy_ff         <= pose_ff ? qy_ff : '0;
         rsp_qz_ff         <= pose_ff ? qz_ff : '0;
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = rsp_accepted_ff;
   assign rsp_fix_code   = rsp_fix_code_ff;
   assign rsp_pose_valid = rsp_pose_valid_ff;
   assign rsp_east_mm    = rsp_east_ff;
   assign rsp_north_mm   = rsp_north_ff;
   assign rsp_up_mm      = rsp_up_ff;
   assign rsp_quat_w     = rsp_qw_ff;
   assign rsp_quat_x     = rsp_qx_ff;
   assign rsp_quat_y     = rsp_qy_ff;
   assign rsp_quat_z     = rsp_qz_ff;

endmodule

@@ src/gftlp_checker.sv @@
// ---------------------------------------------------------------------------
// GNSS fix to local pose: port checker
// Concurrent checks on the top-level ports, attached by bind.
// ---------------------------------------------------------------------------
`include "gnss_fix_to_local_pose_macros.svh"

module gftlp_checker import gftlp_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_accepted,
   input logic [1:0]         rsp_fix_code,
   input logic               rsp_pose_valid,
   input logic signed [31:0] rsp_east_mm,
   input logic signed [31:0] rsp_north_mm,
   input logic signed [31:0] rsp_up_mm,
   input logic signed [15:0] rsp_quat_w,
   input logic signed [15:0] rsp_quat_x,
   input logic signed [15:0] rsp_quat_y,
   input logic signed [15:0] rsp_quat_z
);

   `GFTLP_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "accepted word did not make the block busy")
   `GFTLP_ASSERT_NEXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid, "stalled result word dropped")
   `GFTLP_ASSERT_SAME(a_reject_code, rsp_valid && !rsp_accepted, (rsp_fix_code == FixNone) && !rsp_pose_valid, "rejected fix carries a code or pose")
   `GFTLP_ASSERT_SAME(a_pose_needs_ok, rsp_valid && rsp_pose_valid, rsp_accepted, "pose given for a rejected fix")
   `GFTLP_ASSERT_SAME(a_no_pose_zero, rsp_valid && !rsp_pose_valid, (rsp_east_mm == 0) && (rsp_north_mm == 0) && (rsp_up_mm == 0) && (rsp_quat_w == 0) && (rsp_quat_x == 0) && (rsp_quat_y == 0) && (rsp_quat_z == 0), "fields not zero without a pose")

endmodule

bind gnss_fix_to_local_pose gftlp_checker u_gftlp_checker (.*);

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// GNSS fix to local pose testbench
// Drives GNSS fixes through the valid/stall input channel, predicts each pose
// with a bit-exact fixed-point model, and checks every result word in order.
// ---------------------------------------------------------------------------
typedef struct packed {
   logic               ok;
   logic [1:0]         cls;
   logic signed [30:0] lat;
   logic signed [31:0] lon;
   logic signed [25:0] alt;
   logic [15:0]        yaw;
   logic signed [14:0] pitch;
   logic signed [15:0] roll;
} fix_word_type;

typedef struct packed {
   logic               accepted;
   logic [1:0]         fix_code;
   logic               pose_valid;
   logic signed [31:0] east;
   logic signed [31:0] north;
   logic signed [31:0] up;
   logic signed [15:0] qw;
   logic signed [15:0] qx;
   logic signed [15:0] qy;
   logic signed [15:0] qz;
} pose_word_type;

class pose_scoreboard;
   bit                 ref_held;
   longint             ref_lat;
   longint             ref_lon;
   longint             ref_alt;
   pose_word_type      pending_poses[$];
   int                 errors;

   function void clear_reference();
      ref_held = 0;
      ref_lat = 0;
      ref_lon = 0;
      ref_alt = 0;
   endfunction

   function longint round_shr(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function bit [31:0] binary_angle(longint v, longint mul, int sh);
      longint unsigned mag;
      bit [31:0] b;
      mag = (v < 0) ? -v : v;
      b = 32'((mag * longint'(mul)) >> sh);
      return (v < 0) ? 32'(0) - b : b;
   endfunction

   function longint atan_step(int i);
      longint t[28];
      t = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
            64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
            64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
            64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
            64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
            64'h00000014, 64'h0000000A, 64'h00000005};
      return t[i];
   endfunction

   function void rotate(bit [31:0] a, output longint c, output longint s);
      bit [31:0] q;
      bit [31:0] r;
      longint z;
      longint x;
      longint y;
      longint nx;
      longint ny;
      q = ((a + 32'h20000000) >> 30) & 3;
      r = a - q * 32'h40000000;
      z = longint'($signed(r));
      x = 652032874;
      y = 0;
      for (int i = 0; i < 28; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z -= atan_step(i);
         end else begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z += atan_step(i);
         end
         x = nx;
         y = ny;
      end
      case (q)
         0: begin c = x; s = y; end
         1: begin c = -y; s = x; end
         2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   function longint triple(longint a, longint b, longint c);
      return ((a * b) >>> 30) * c;
   endfunction

   function logic signed [15:0] to_q14(longint v);
      longint r;
      r = round_shr(v, 46);
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return 16'(r);
   endfunction

   function void note_fix(fix_word_type f);
      pose_word_type p;
      longint lat, lon, alt, dlat, dlon, cm, sm, c16, p8;
      longint cy, sy, cp, sp, cr, sr;
      p = '{default: 0};
      p.fix_code = 2'd3;
      lat = f.lat;
      lon = f.lon;
      alt = f.alt;
      if (f.ok) begin
         p.accepted = 1;
         p.fix_code = 2'd3 - f.cls;
         if (!ref_held && f.cls >= 1) begin
            ref_lat = lat;
            ref_lon = lon;
            ref_alt = alt;
            ref_held = 1;
         end
         if (ref_held) begin
            dlat = lat - ref_lat;
            dlon = lon - ref_lon;
            rotate(binary_angle(lat + ref_lat, 64'd2562047788, 32), cm, sm);
            c16 = round_shr(cm, 14);
            p8 = (dlon * 186554130) >>> 16;
            p.pose_valid = 1;
            p.east = 32'(clamp32(round_shr(p8 * c16, 24)));
            p.north = 32'(clamp32(round_shr(dlat * 186554130, 24)));
            p.up = 32'(clamp32(alt - ref_alt));
            rotate(binary_angle(longint'(f.yaw), 64'd3909374677, 16), cy, sy);
            rotate(binary_angle(longint'(f.pitch), 64'd3909374677, 16), cp, sp);
            rotate(binary_angle(longint'(f.roll), 64'd3909374677, 16), cr, sr);
            p.qw = to_q14(triple(cr, cp, cy) + triple(sr, sp, sy));
            p.qx = to_q14(triple(sr, cp, cy) - triple(cr, sp, sy));
            p.qy = to_q14(triple(cr, sp, cy) + triple(sr, cp, sy));
            p.qz = to_q14(triple(cr, cp, sy) - triple(sr, sp, cy));
         end
      end
      pending_poses.push_back(p);
   endfunction

   function void check_pose(pose_word_type a);
      pose_word_type e;
      if (pending_poses.size() == 0) begin
         $display("%0t: unexpected result word, actual %p", $time, a);
         errors++;
         return;
      end
      e = pending_poses.pop_front();
      if (a !== e) begin
         $display("%0t: result mismatch, expected %p, actual %p", $time, e, a);
         errors++;
      end
   endfunction
endclass

module testbench;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic               req_module_ok = 0;
   logic [1:0]         req_solution_class = 0;
   logic signed [30:0] req_latitude = 0;
   logic signed [31:0] req_longitude = 0;
   logic signed [25:0] req_altitude = 0;
   logic [15:0]        req_heading_angle = 0;
   logic signed [14:0] req_pitch_angle = 0;
   logic signed [15:0] req_roll_angle = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic               rsp_accepted;
   logic [1:0]         rsp_fix_code;
   logic               rsp_pose_valid;
   logic signed [31:0] rsp_east_mm, rsp_north_mm, rsp_up_mm;
   logic signed [15:0] rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;

   pose_scoreboard board;
   int             send_idle_pct = 18;
   int             recv_idle_pct = 75;
   int             hold_cycles = 0;

   gnss_fix_to_local_pose dut (.*);

   always #5 clock = ~clock;

   initial begin
      #300000000;
      $display("testbench: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_pose('{rsp_accepted, rsp_fix_code, rsp_pose_valid, rsp_east_mm,
                            rsp_north_mm, rsp_up_mm, rsp_quat_w, rsp_quat_x,
                            rsp_quat_y, rsp_quat_z});
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic send_fix(fix_word_type f);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_valid <= 1;
      req_module_ok <= f.ok;
      req_solution_class <= f.cls;
      req_latitude <= f.lat;
      req_longitude <= f.lon;
      req_altitude <= f.alt;
      req_heading_angle <= f.yaw;
      req_pitch_angle <= f.pitch;
      req_roll_angle <= f.roll;
      do @(posedge clock); while (req_stall);
      board.note_fix(f);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending_poses.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   function automatic fix_word_type random_fix();
      fix_word_type f;
      int k;
      f.ok = ($urandom_range(99) < 90);
      f.cls = $urandom_range(3);
      k = $urandom_range(9);
      if (k < 6) begin
         f.lat = 31'($signed($urandom_range(2000000)) - 1000000 + 450000000);
         f.lon = $signed($urandom_range(2000000)) - 1000000 + 300000000;
         f.alt = 26'($signed($urandom_range(200000)) - 100000);
      end else begin
         f.lat = 31'($urandom);
         f.lon = $urandom;
         f.alt = 26'($urandom);
      end
      f.yaw = (k == 9) ? 16'($urandom) : 16'($urandom_range(35999));
      f.pitch = (k == 9) ? 15'($urandom) : 15'($signed($urandom_range(18000)) - 9000);
      f.roll = (k == 9) ? 16'($urandom) : 16'($signed($urandom_range(36000)) - 18000);
      return f;
   endfunction

   initial begin
      fix_word_type f;
      board = new();
      board.clear_reference();
      repeat (6) @(negedge clock);
      reset <= 0;
      send_fix('{0, 3, 100, 200, 300, 0, 0, 0});
      send_fix('{1, 0, 100, 200, 300, 0, 0, 0});
      send_fix('{1, 1, 31'sd900000000, 32'sd1800000000, 26'sd20000000, 0, 0, 0});
      send_fix('{1, 2, -31'sd900000000, -32'sd1800000000, -26'sd1000000,
                 16'd35999, 15'sd9000, 16'sd18000});
      send_fix('{1, 3, 31'sd900000000, -32'sd1800000000, 0, 16'd0,
                 -15'sd9000, -16'sd18000});
      send_fix('{1, 0, 0, 0, 0, 16'hFFFF, 15'sh4000, 16'sh8000});
      send_fix('{1, 3, 31'sh3FFFFFFF, 32'sh7FFFFFFF, 26'sh1FFFFFF,
                 16'd9000, 15'sh3FFF, 16'sh7FFF});
      send_fix('{1, 1, 31'sh40000000, 32'sh80000000, 26'sh2000000,
                 16'd18000, 15'sd4500, -16'sd9000});
      send_fix('{0, 1, 0, 0, 0, 0, 0, 0});
      for (int i = 0; i < 400; i++) begin
         if (i == 133) begin
            send_idle_pct = 75;
            recv_idle_pct = 18;
         end
         if (i == 266) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (i == 300) hold_cycles = 2000;
         if (i == 350) drain();
         send_fix(random_fix());
      end
      drain();
      if (board.errors == 0 && board.pending_poses.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end
endmodule
